FILE: design/urst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package urst_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int LIVE_W      = $clog2(TABLE_SLOTS + 1);

    localparam logic [31:0] BROADCAST_IP = 32'hFFFF_FFFF;
    localparam logic [15:0] P2P_PORT     = 16'd8054;
    localparam logic [31:0] PING_GAP     = 32'd5;
    localparam logic [1:0]  PING_LIMIT   = 2'd2;
    localparam logic [11:0] TIMEOUT_MAX  = 12'd3600;
    localparam logic [11:0] TIMEOUT_RST  = 12'd10;

    localparam logic [7:0] CMD_RELAY     = 8'd0;
    localparam logic [7:0] CMD_P2P       = 8'd1;
    localparam logic [7:0] CMD_DISC      = 8'd2;
    localparam logic [7:0] CMD_KEEPALIVE = 8'd3;
    localparam logic [7:0] CMD_CENSUS    = 8'd4;
    localparam logic [7:0] CMD_ECHO      = 8'd5;

    localparam logic [1:0] KIND_FWD   = 2'd0;
    localparam logic [1:0] KIND_PING  = 2'd1;
    localparam logic [1:0] KIND_ECHO  = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    localparam logic [0:0] REG_TIMEOUT = 1'd0;
    localparam logic [0:0] REG_LIMIT   = 1'd1;

    typedef struct packed {
        logic [0:0]  action;
        logic [31:0] now_seconds;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [7:0]  command;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [7:0]  pay_byte0;
        logic [7:0]  pay_byte1;
        logic [7:0]  pay_byte4;
        logic [7:0]  pay_byte5;
        logic [15:0] payload_length;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] to_ip;
        logic [15:0] to_port;
        logic [7:0]  header_command;
        logic [31:0] origin_ip;
        logic [15:0] origin_port;
        logic [31:0] value;
        logic [2:0]  game_code;
        logic [0:0]  last;
    } out_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [15:0] port;
        logic        p2p;
        logic [2:0]  game;
        logic [31:0] rx_stamp;
        logic [31:0] probe_stamp;
        logic [1:0]  probe_cnt;
    } entry_t;

    function automatic entry_t entry_free(entry_t e);
        entry_t r;
        r = e;
        r.valid       = 1'b0;
        r.p2p         = 1'b0;
        r.game        = 3'd0;
        r.rx_stamp    = 32'd0;
        r.probe_stamp = 32'd0;
        r.probe_cnt   = 2'd0;
        return r;
    endfunction

    function automatic logic later_by(logic [31:0] now, logic [31:0] stamp,
                                      logic [31:0] gap);
        return (now > stamp) && ((now - stamp) > gap);
    endfunction

    function automatic logic [2:0] detect_game(logic [7:0] b0, logic [7:0] b1,
                                               logic [7:0] b4, logic [7:0] b5);
        logic [2:0] g;
        if (b0 == 8'h34 && b1 == 8'h12)      g = 3'd1;
        else if (b0 == 8'h35 && b1 == 8'h12) g = 3'd2;
        else if (b4 == 8'h35 && b5 == 8'h12) g = 3'd3;
        else if (b4 == 8'h35 && b5 == 8'h13) g = 3'd4;
        else if (b4 == 8'h35 && b5 == 8'h14) g = 3'd5;
        else if (b4 == 8'h36 && b5 == 8'h12) g = 3'd6;
        else                                 g = 3'd0;
        return g;
    endfunction

endpackage
`default_nettype wire

FILE: design/udp_relay_session_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Session table as a ring of TABLE_SLOTS cells rotating past one shared head unit.
// Per transaction: an accept step, a search pass over all TABLE_SLOTS cells, an update pass over
// all cells when the sender is known or admitted, a sweep pass and a flush step. Queries: a count
// pass and eight results, no update pass; echoes: one result; idle ticks: sweep only. Output
// stalls freeze the ring.
// Synchronous reset empties all slots and sets registers to defaults; slot payload is kept.
module udp_relay_session_table_unit
    import urst_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_COUNT  = 3'd1;
    localparam logic [2:0] S_QEMIT  = 3'd2;
    localparam logic [2:0] S_ECHO   = 3'd3;
    localparam logic [2:0] S_SEARCH = 3'd4;
    localparam logic [2:0] S_ACT    = 3'd5;
    localparam logic [2:0] S_SWEEP  = 3'd6;
    localparam logic [2:0] S_FLUSH  = 3'd7;

    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TABLE_SLOTS - 1);

    logic [11:0] timeout_reg;
    logic [4:0]  limit_reg;
    logic [2:0]  state_reg;
    in_t         it_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [2:0]  qi_reg;
    logic [LIVE_W-1:0] live_reg;
    logic [LIVE_W-1:0] cnt_reg [8];
    logic        me_found_reg;
    logic [IDX_W-1:0] me_idx_reg;
    logic        spare_found_reg;
    logic [IDX_W-1:0] spare_idx_reg;
    logic        alloc_reg;
    logic        found_reg;
    logic        pend_valid_reg;
    out_t        pend_reg;
    logic        m_valid_reg;
    out_t        m_data_reg;

    entry_t cell_q [TABLE_SLOTS];
    entry_t cell_d [TABLE_SLOTS];
    entry_t head;
    entry_t head_new;
    entry_t ent;
    logic   gen_valid;
    out_t   gen;
    out_t   pend_last;
    logic   flush_go;
    logic   adv;
    logic   shift_en;
    logic   pass_end;
    logic   in_pass;
    logic [11:0] lim;
    logic [2:0]  game;
    logic   fwd;
    logic   dvalid;
    logic   bcast;
    logic   me_hit;
    logic   fin_me_found;
    logic   fin_spare_found;
    logic [IDX_W-1:0] fin_spare;
    logic [LIVE_W-1:0] live_fin;
    logic   cfg_wr;

    function automatic logic dmatch(entry_t e, in_t it);
        return e.valid && e.ip == it.dest_ip &&
               (e.port == it.dest_port || (it.dest_port == P2P_PORT && e.p2p));
    endfunction

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_SLOTS; gi++) begin : g_cell
            if (gi == TABLE_SLOTS - 1) begin : g_tail
                assign cell_d[gi] = head_new;
            end else begin : g_mid
                assign cell_d[gi] = cell_q[gi + 1];
            end
            urst_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .din      (cell_d[gi]),
                .dout     (cell_q[gi])
            );
        end
    endgenerate

    assign head    = cell_q[0];
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    assign lim = (timeout_reg == 12'd0) ? 12'd1 :
                 (timeout_reg > TIMEOUT_MAX) ? TIMEOUT_MAX : timeout_reg;
    assign game   = detect_game(it_reg.pay_byte0, it_reg.pay_byte1,
                                it_reg.pay_byte4, it_reg.pay_byte5);
    assign fwd    = (it_reg.command != CMD_DISC) && (it_reg.command != CMD_KEEPALIVE);
    assign dvalid = (it_reg.dest_ip != 32'd0) && (it_reg.dest_port != 16'd0);
    assign bcast  = (it_reg.dest_ip == BROADCAST_IP);

    assign me_hit = head.valid && head.ip == it_reg.src_ip && head.port == it_reg.src_port;
    assign fin_me_found    = me_found_reg || me_hit;
    assign fin_spare_found = spare_found_reg || !head.valid;
    assign fin_spare       = spare_found_reg ? spare_idx_reg : pos_reg;
    assign live_fin        = live_reg + LIVE_W'(head.valid);

    assign adv      = !gen_valid || !pend_valid_reg || !m_valid_reg || m_ready;
    assign in_pass  = (state_reg == S_COUNT) || (state_reg == S_SEARCH) ||
                      (state_reg == S_ACT) || (state_reg == S_SWEEP);
    assign shift_en = in_pass && adv;
    assign pass_end = shift_en && (pos_reg == LAST_POS);
    assign flush_go = (state_reg == S_FLUSH) && pend_valid_reg && (!m_valid_reg || m_ready);

    always_comb begin
        pend_last      = pend_reg;
        pend_last.last = 1'b1;
    end

    always_comb begin
        head_new  = head;
        ent       = head;
        gen_valid = 1'b0;
        gen       = '0;
        case (state_reg)
            S_QEMIT: begin
                gen_valid          = 1'b1;
                gen.kind           = KIND_QUERY;
                gen.to_ip          = it_reg.src_ip;
                gen.to_port        = it_reg.src_port;
                gen.header_command = CMD_CENSUS;
                gen.value          = (qi_reg == 3'd7) ? 32'(live_reg) : 32'(cnt_reg[qi_reg]);
                gen.game_code      = qi_reg;
            end
            S_ECHO: begin
                gen_valid          = 1'b1;
                gen.kind           = KIND_ECHO;
                gen.to_ip          = it_reg.src_ip;
                gen.to_port        = P2P_PORT;
                gen.header_command = CMD_ECHO;
                gen.value          = it_reg.dest_ip;
            end
            S_ACT: begin
                gen.kind           = KIND_FWD;
                gen.header_command = it_reg.command;
                gen.origin_ip      = it_reg.src_ip;
                gen.origin_port    = it_reg.src_port;
                if (pos_reg == me_idx_reg) begin
                    if (alloc_reg) begin
                        ent       = entry_free(head);
                        ent.valid = 1'b1;
                        ent.ip    = it_reg.src_ip;
                        ent.port  = it_reg.src_port;
                    end
                    if (it_reg.command == CMD_DISC) begin
                        ent = entry_free(ent);
                    end else if (!fwd) begin
                        ent.rx_stamp  = it_reg.now_seconds;
                        ent.probe_cnt = 2'd0;
                    end else if (!dvalid) begin
                        if (ent.game == 3'd0) begin
                            ent = entry_free(ent);
                        end
                    end else begin
                        if (bcast) begin
                            ent.game = game;
                            ent.p2p  = (it_reg.command == CMD_P2P);
                        end else if (!found_reg && dmatch(ent, it_reg)) begin
                            gen_valid   = 1'b1;
                            gen.to_ip   = ent.ip;
                            gen.to_port = ent.port;
                        end
                        ent.rx_stamp  = it_reg.now_seconds;
                        ent.probe_cnt = 2'd0;
                    end
                    head_new = ent;
                end else if (fwd && dvalid) begin
                    gen.to_ip   = head.ip;
                    gen.to_port = head.port;
                    if (bcast) begin
                        if (it_reg.command == CMD_P2P) begin
                            gen.origin_port = P2P_PORT;
                        end
                        gen_valid = (it_reg.payload_length != 16'd0) && head.valid &&
                                    (head.game == game || head.game == 3'd0);
                    end else begin
                        gen_valid = !found_reg && dmatch(head, it_reg);
                    end
                end
            end
            S_SWEEP: begin
                if (head.valid && later_by(it_reg.now_seconds, head.rx_stamp, 32'(lim)) &&
                    later_by(it_reg.now_seconds, head.probe_stamp, PING_GAP)) begin
                    if (head.probe_cnt > PING_LIMIT) begin
                        head_new = entry_free(head);
                    end else begin
                        gen_valid              = 1'b1;
                        gen.kind               = KIND_PING;
                        gen.to_ip              = head.ip;
                        gen.to_port            = head.port;
                        gen.header_command     = CMD_KEEPALIVE;
                        gen.value              = 32'(head.probe_cnt);
                        head_new.probe_stamp   = it_reg.now_seconds;
                        head_new.probe_cnt     = head.probe_cnt + 2'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RST;
            limit_reg   <= 5'd0;
        end else if (cfg_wr) begin
            case (paddr[2:2])
                REG_TIMEOUT: timeout_reg <= pwdata[11:0];
                REG_LIMIT:   limit_reg   <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2:2])
            REG_TIMEOUT: prdata = 32'(timeout_reg);
            REG_LIMIT:   prdata = 32'(limit_reg);
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            it_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            pos_reg         <= '0;
            qi_reg          <= 3'd0;
            live_reg        <= '0;
            me_found_reg    <= 1'b0;
            me_idx_reg      <= '0;
            spare_found_reg <= 1'b0;
            spare_idx_reg   <= '0;
            alloc_reg       <= 1'b0;
            found_reg       <= 1'b0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
            for (int k = 0; k < 8; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            if (gen_valid && adv && pend_valid_reg) begin
                m_data_reg  <= pend_reg;
                m_valid_reg <= 1'b1;
            end else if (flush_go) begin
                m_data_reg  <= pend_last;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (gen_valid && adv) begin
                pend_reg       <= gen;
                pend_valid_reg <= 1'b1;
            end
            if (shift_en) begin
                pos_reg <= (pos_reg == LAST_POS) ? '0 : pos_reg + IDX_W'(1);
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        live_reg        <= '0;
                        me_found_reg    <= 1'b0;
                        spare_found_reg <= 1'b0;
                        qi_reg          <= 3'd0;
                        for (int k = 0; k < 8; k++) begin
                            cnt_reg[k] <= '0;
                        end
                        if (s_data.action == 1'b1) begin
                            state_reg <= S_SWEEP;
                        end else if (s_data.command == CMD_CENSUS) begin
                            state_reg <= S_COUNT;
                        end else if (s_data.command == CMD_ECHO) begin
                            state_reg <= S_ECHO;
                        end else begin
                            state_reg <= S_SEARCH;
                        end
                    end
                end
                S_COUNT: begin
                    if (shift_en && head.valid) begin
                        cnt_reg[head.game] <= cnt_reg[head.game] + LIVE_W'(1);
                        live_reg           <= live_reg + LIVE_W'(1);
                    end
                    if (pass_end) begin
                        state_reg <= S_QEMIT;
                    end
                end
                S_QEMIT: begin
                    if (adv) begin
                        qi_reg <= qi_reg + 3'd1;
                        if (qi_reg == 3'd7) begin
                            state_reg <= S_SWEEP;
                        end
                    end
                end
                S_ECHO: begin
                    if (adv) begin
                        state_reg <= S_SWEEP;
                    end
                end
                S_SEARCH: begin
                    if (shift_en) begin
                        live_reg <= live_fin;
                        if (me_hit && !me_found_reg) begin
                            me_found_reg <= 1'b1;
                            me_idx_reg   <= pos_reg;
                        end
                        if (!head.valid && !spare_found_reg) begin
                            spare_found_reg <= 1'b1;
                            spare_idx_reg   <= pos_reg;
                        end
                    end
                    if (pass_end) begin
                        found_reg <= 1'b0;
                        if (fin_me_found) begin
                            alloc_reg <= 1'b0;
                            state_reg <= S_ACT;
                        end else if (it_reg.command == CMD_DISC ||
                                     (limit_reg != 5'd0 && 8'(live_fin) >= 8'(limit_reg)) ||
                                     !fin_spare_found) begin
                            state_reg <= S_SWEEP;
                        end else begin
                            alloc_reg  <= 1'b1;
                            me_idx_reg <= fin_spare;
                            state_reg  <= S_ACT;
                        end
                    end
                end
                S_ACT: begin
                    if (gen_valid && adv && !bcast) begin
                        found_reg <= 1'b1;
                    end
                    if (pass_end) begin
                        state_reg <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (pass_end) begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (!pend_valid_reg) begin
                        state_reg <= S_IDLE;
                    end else if (flush_go) begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: design/urst_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module urst_cell
    import urst_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   shift_en,
    input  wire entry_t din,
    output entry_t      dout
);

    logic   valid_reg;
    entry_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= din;
        end
    end

    always_comb begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule
`default_nettype wire
